// ===== rtl/nearest_unmarked_point_search_assert.svh =====
// assertion macros used by the checker file nups_checker
`ifndef NEAREST_UNMARKED_POINT_SEARCH_ASSERT_SVH
`define NEAREST_UNMARKED_POINT_SEARCH_ASSERT_SVH
`define NUPS_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("label failed");
`define NUPS_ASSERT_NXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("label failed");
`endif

// ===== rtl/nups_pkg.sv =====
// ----------------------------------------------------------------------------
// nups_pkg
// shared constants and types for the nearest unmarked point search
// ----------------------------------------------------------------------------
package nups_pkg;
  localparam int MaxPoints = 1024;
  localparam int IdxW = $clog2(MaxPoints);
  localparam int CntW = IdxW + 1;
  localparam int CoordW = 8;
  localparam int MaskW = 64;
  localparam int OwnW = 6;
  localparam int DistW = 20;
  localparam logic [DistW-1:0] DistLimit = 20'd999999;

  localparam logic [1:0] FuncLoad = 2'd0;
  localparam logic [1:0] FuncNear = 2'd1;
  localparam logic [1:0] FuncMark = 2'd2;

  localparam logic CfgOwner = 1'b0;
  localparam logic CfgCount = 1'b1;

  // one candidate travelling down the cell row
  typedef struct packed {
    logic              vld;
    logic [IdxW-1:0]   idx;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
    logic              marked;
  } cand_t;

  // running best held in the last stage of the search module
  typedef struct packed {
    logic              hit;
    logic [DistW-1:0]  sq_dist;
    logic [IdxW-1:0]   idx;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } best_t;
endpackage

// ===== rtl/nups_cell.sv =====
// ----------------------------------------------------------------------------
// nups_cell
// one pipeline cell: computes one axis term and passes the candidate on
// ----------------------------------------------------------------------------
module nups_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  nups_pkg::cand_t            cand_i,
  input  logic [nups_pkg::CoordW-1:0] a_i,
  input  logic [nups_pkg::CoordW-1:0] b_i,
  input  logic [nups_pkg::DistW-1:0] acc_i,
  output nups_pkg::cand_t            cand_o,
  output logic [nups_pkg::DistW-1:0] acc_o
);
  logic [nups_pkg::CoordW-1:0] diff;
  logic [nups_pkg::DistW-1:0]  acc_d;
  nups_pkg::cand_t cand_q;
  logic [nups_pkg::DistW-1:0] acc_q;

  assign diff = (a_i > b_i) ? a_i - b_i : b_i - a_i;
  assign acc_d = acc_i + nups_pkg::DistW'(diff) * nups_pkg::DistW'(diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      acc_q <= '0;
    end else begin
      cand_q <= cand_i;
      acc_q <= acc_d;
    end
  end

  assign cand_o = cand_q;
  assign acc_o = acc_q;
endmodule

// ===== rtl/nearest_unmarked_point_search.sv =====
// ----------------------------------------------------------------------------
// nearest_unmarked_point_search
// point table with nearest unmarked query and mark-by-coordinate search
// ----------------------------------------------------------------------------
// start with busy low transfers one command (func_i and its fields).
// a query or mark streams slots 0..n-1 from the table memory, with n the
// point_count capped at the table size, one slot per cycle, through a row
// of three distance cells, one per axis; the last stage keeps the running
// best (query) or first match (mark), then sets the found slot's owner bit
// by one read-modify-write.
// after the scan and drain, a found point passes through the read and write
// states to done, and a miss goes straight to done, as do loads, unused
// commands and n = 0; the done state raises done_o. one command is handled
// at a time and busy stays high meanwhile; the next start is taken while done_o is high.
// done_o pulses for one cycle with the result; the receiver cannot stall.
// configuration writes (cfg_valid_i/cfg_ready_o) are always accepted;
// index 0 is owner_index and 1 is point_count.
// reset clears control state only; table contents are undefined until loaded.
module nearest_unmarked_point_search (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   func_i,
  input  logic [9:0]                   entry_index_i,
  input  logic [7:0]                   pos_x_i,
  input  logic [7:0]                   pos_y_i,
  input  logic [7:0]                   pos_z_i,
  input  logic [63:0]                  mask_in_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic [7:0]                   hit_x_o,
  output logic [7:0]                   hit_y_o,
  output logic [7:0]                   hit_z_o,
  output logic [9:0]                   hit_index_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic                         cfg_index_i,
  input  logic [10:0]                  cfg_data_i
);
  localparam int IdxW = nups_pkg::IdxW;
  localparam int CntW = nups_pkg::CntW;
  localparam int CW = nups_pkg::CoordW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StRead  = 3'd3;
  localparam logic [2:0] StWrite = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  logic [nups_pkg::OwnW-1:0] owner_q;
  logic [CntW-1:0] count_q;
  logic [2:0] state_q;
  logic [1:0] func_q;
  logic [CW-1:0] px_q, py_q, pz_q;
  logic [IdxW-1:0] scan_q;
  logic [CntW-1:0] scan_len;
  logic [2:0] drain_q;
  logic load_q;
  logic [IdxW-1:0] load_idx_q;
  logic [3*CW-1:0] load_pt_q;
  logic [63:0] load_mask_q;

  logic [3*CW-1:0] coord_mem [nups_pkg::MaxPoints];
  logic [63:0]     mask_mem  [nups_pkg::MaxPoints];
  logic [3*CW-1:0] coord_rd_q;
  logic [63:0]     mask_rd_q;
  logic            rd_vld_q;
  logic [IdxW-1:0] rd_idx_q;

  nups_pkg::cand_t c0, c1, c2, c3;
  logic [nups_pkg::DistW-1:0] a1, a2, a3;
  nups_pkg::best_t best_q;
  logic [IdxW-1:0] rd_addr;
  logic accept, scan_last, is_near, better;

  assign accept = start && !busy;
  assign busy = state_q != StIdle;
  assign cfg_ready_o = 1'b1;
  assign scan_len = (count_q > CntW'(nups_pkg::MaxPoints)) ? CntW'(nups_pkg::MaxPoints)
                                                           : count_q;
  assign scan_last = {1'b0, scan_q} == scan_len - CntW'(1);
  assign is_near = func_q == nups_pkg::FuncNear;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
      count_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == nups_pkg::CfgOwner) owner_q <= cfg_data_i[nups_pkg::OwnW-1:0];
      else count_q <= cfg_data_i;
    end
  end

  assign rd_addr = (state_q == StRead) ? best_q.idx : scan_q;

  // table memories: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (load_q) begin
      coord_mem[load_idx_q] <= load_pt_q;
      mask_mem[load_idx_q] <= load_mask_q;
    end else if (state_q == StWrite) begin
      mask_mem[best_q.idx] <= mask_rd_q | (64'd1 << owner_q);
    end
    coord_rd_q <= coord_mem[rd_addr];
    mask_rd_q <= mask_mem[rd_addr];
    rd_idx_q <= scan_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= state_q == StScan;
    end
  end

  assign c0.vld = rd_vld_q;
  assign c0.idx = rd_idx_q;
  assign c0.x = coord_rd_q[3*CW-1:2*CW];
  assign c0.y = coord_rd_q[2*CW-1:CW];
  assign c0.z = coord_rd_q[CW-1:0];
  assign c0.marked = mask_rd_q[owner_q];

  nups_cell u_cell_x (.clk_i, .rst_ni, .cand_i(c0), .a_i(c0.x), .b_i(px_q),
                      .acc_i('0), .cand_o(c1), .acc_o(a1));
  nups_cell u_cell_y (.clk_i, .rst_ni, .cand_i(c1), .a_i(c1.y), .b_i(py_q),
                      .acc_i(a1), .cand_o(c2), .acc_o(a2));
  nups_cell u_cell_z (.clk_i, .rst_ni, .cand_i(c2), .a_i(c2.z), .b_i(pz_q),
                      .acc_i(a2), .cand_o(c3), .acc_o(a3));

  always_comb begin
    if (is_near) begin
      better = c3.vld && !c3.marked && (a3 < best_q.sq_dist);
    end else begin
      better = c3.vld && !best_q.hit && c3.x == px_q && c3.y == py_q && c3.z == pz_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      load_q <= 1'b0;
      done_o <= 1'b0;
      best_q <= '0;
    end else begin
      load_q <= 1'b0;
      done_o <= 1'b0;
      case (state_q)
        StIdle: begin
          if (accept) begin
            best_q.hit <= 1'b0;
            best_q.sq_dist <= nups_pkg::DistLimit;
            best_q.idx <= '0;
            best_q.x <= '0;
            best_q.y <= '0;
            best_q.z <= '0;
            if ((func_i == nups_pkg::FuncNear || func_i == nups_pkg::FuncMark)
                && scan_len != '0) begin
              state_q <= StScan;
            end else begin
              load_q <= func_i == nups_pkg::FuncLoad;
              state_q <= StDone;
            end
          end
        end
        StScan: if (scan_last) state_q <= StDrain;
        StDrain: begin
          if (drain_q == 3'd4) state_q <= best_q.hit || better ? StRead : StDone;
        end
        StRead: state_q <= StWrite;
        StWrite: state_q <= StDone;
        StDone: begin
          done_o <= 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
      if ((state_q == StScan || state_q == StDrain) && better) begin
        best_q.hit <= 1'b1;
        best_q.sq_dist <= a3;
        best_q.idx <= c3.idx;
        best_q.x <= c3.x;
        best_q.y <= c3.y;
        best_q.z <= c3.z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
      load_idx_q <= entry_index_i;
      load_pt_q <= {pos_x_i, pos_y_i, pos_z_i};
      load_mask_q <= mask_in_i;
      scan_q <= '0;
      drain_q <= '0;
    end else begin
      if (state_q == StScan) scan_q <= scan_q + IdxW'(1);
      if (state_q == StDrain) drain_q <= drain_q + 3'd1;
    end
  end

  assign found_o = best_q.hit;
  assign hit_x_o = best_q.x;
  assign hit_y_o = best_q.y;
  assign hit_z_o = best_q.z;
  assign hit_index_o = best_q.idx;
endmodule

// ===== rtl/nups_checker.sv =====
// ----------------------------------------------------------------------------
// nups_checker
// port-level checks on the command and result sequence
// ----------------------------------------------------------------------------
`include "nearest_unmarked_point_search_assert.svh"
module nups_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic       found_o,
  input logic [9:0] hit_index_o,
  input logic [7:0] hit_x_o
);
  `NUPS_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start && !busy, busy)
  `NUPS_ASSERT_IMP(a_done_free, clk_i, rst_ni, done_o, !busy)
  `NUPS_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `NUPS_ASSERT_IMP(a_miss_zero, clk_i, rst_ni, done_o && !found_o,
                   hit_index_o == 10'd0 && hit_x_o == 8'd0)
endmodule

bind nearest_unmarked_point_search nups_checker u_nups_checker (
  .clk_i, .rst_ni, .start, .busy, .done_o, .found_o, .hit_index_o, .hit_x_o
);

// ===== tb/nearest_unmarked_point_search_test.sv =====
// ----------------------------------------------------------------------------
// nearest_unmarked_point_search_test
// self-checking bench: a directed command table whose typed rows expect a miss, then
// random phases with varying sender gaps, other results compared against a behavioral predictor
// of the point table and its visited masks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_unmarked_point_search_test;

  localparam logic [1:0] FuncNone = 2'd3;

  typedef struct {
    logic       found;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] z;
    logic [9:0] idx;
  } hit_t;

  typedef struct {
    bit          cfg;
    logic        cidx;
    logic [10:0] cdata;
    logic [1:0]  func;
    logic [9:0]  slot;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  z;
    logic [63:0] mask;
    bit          typed;
    hit_t        hit;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = '0;
  logic [9:0]  entry_index_i = '0;
  logic [7:0]  pos_x_i = '0;
  logic [7:0]  pos_y_i = '0;
  logic [7:0]  pos_z_i = '0;
  logic [63:0] mask_in_i = '0;
  logic        done_o;
  logic        found_o;
  logic [7:0]  hit_x_o;
  logic [7:0]  hit_y_o;
  logic [7:0]  hit_z_o;
  logic [9:0]  hit_index_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [10:0] cfg_data_i = '0;

  // predictor state
  logic [7:0]  tbl_x [nups_pkg::MaxPoints];
  logic [7:0]  tbl_y [nups_pkg::MaxPoints];
  logic [7:0]  tbl_z [nups_pkg::MaxPoints];
  logic [63:0] tbl_mask [nups_pkg::MaxPoints];
  logic [5:0]  cur_owner;
  logic [10:0] cur_count;

  hit_t pending_hits[$];
  row_t rows[$];
  int   mismatches = 0;
  int   filled = 0;

  always #1 clk_i = ~clk_i;

  nearest_unmarked_point_search i_dut (.*);

  function automatic hit_t search_table(logic [1:0] f, logic [9:0] slot, logic [7:0] x,
                                        logic [7:0] y, logic [7:0] z, logic [63:0] mask);
    hit_t h;
    int n;
    int best_d;
    int d;
    int best;
    h = '{found: 1'b0, x: '0, y: '0, z: '0, idx: '0};
    n = (cur_count > nups_pkg::MaxPoints) ? nups_pkg::MaxPoints : int'(cur_count);
    best_d = 999999;
    best = 0;
    if (f == nups_pkg::FuncLoad) begin
      tbl_x[slot] = x;
      tbl_y[slot] = y;
      tbl_z[slot] = z;
      tbl_mask[slot] = mask;
    end else if (f == nups_pkg::FuncNear) begin
      for (int i = 0; i < n; i++) begin
        if (!tbl_mask[i][cur_owner]) begin
          d = (int'(x) - int'(tbl_x[i])) ** 2 + (int'(y) - int'(tbl_y[i])) ** 2
            + (int'(z) - int'(tbl_z[i])) ** 2;
          if (d < best_d) begin
            best_d = d;
            best = i;
            h.found = 1'b1;
          end
        end
      end
    end else if (f == nups_pkg::FuncMark) begin
      for (int i = 0; i < n; i++) begin
        if (!h.found && tbl_x[i] == x && tbl_y[i] == y && tbl_z[i] == z) begin
          best = i;
          h.found = 1'b1;
        end
      end
    end
    if (h.found) begin
      tbl_mask[best][cur_owner] = 1'b1;
      h.x = tbl_x[best];
      h.y = tbl_y[best];
      h.z = tbl_z[best];
      h.idx = best[9:0];
    end
    return h;
  endfunction

  task automatic send_cmd(logic [1:0] f, logic [9:0] slot, logic [7:0] x, logic [7:0] y,
                          logic [7:0] z, logic [63:0] mask, int idle_pct,
                          bit typed = 0, hit_t want = '{1'b0, 8'd0, 8'd0, 8'd0, 10'd0});
    hit_t h;
    if ($urandom_range(99) < idle_pct) begin
      if (start) start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1;
    func_i <= f;
    entry_index_i <= slot;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    mask_in_i <= mask;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    h = search_table(f, slot, x, y, z, mask);
    pending_hits.push_back(typed ? want : h);
  endtask

  // register writes only once the block has drained
  task automatic cfg_write(logic idx, logic [10:0] data);
    if (start) start <= 1'b0;
    @(posedge clk_i);
    while (pending_hits.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == nups_pkg::CfgOwner) cur_owner = data[5:0];
    else cur_count = data;
  endtask

  task automatic fill_to(int target, int idle_pct);
    for (int i = filled; i < target; i++)
      send_cmd(nups_pkg::FuncLoad, i[9:0], 8'($urandom), 8'($urandom), 8'($urandom),
               {$urandom, $urandom}, idle_pct);
    if (target > filled) filled = target;
  endtask

  task automatic add_op(logic [1:0] f, logic [9:0] slot, logic [7:0] x, logic [7:0] y,
                        logic [7:0] z, logic [63:0] mask, bit typed = 0);
    row_t r;
    r = '{cfg: 0, cidx: 0, cdata: 0, func: f, slot: slot, x: x, y: y, z: z, mask: mask,
          typed: typed, hit: '{1'b0, 8'd0, 8'd0, 8'd0, 10'd0}};
    rows.push_back(r);
  endtask

  task automatic add_cfg(logic idx, logic [10:0] data);
    row_t r;
    r = '{cfg: 1, cidx: idx, cdata: data, func: FuncNone, slot: 0, x: 0, y: 0, z: 0, mask: 0,
          typed: 0, hit: '{1'b0, 8'd0, 8'd0, 8'd0, 10'd0}};
    rows.push_back(r);
  endtask

  task automatic random_phase(int idle_pct, int n_items);
    int n;
    int j;
    int k;
    logic [1:0] f;
    n = (cur_count > nups_pkg::MaxPoints) ? nups_pkg::MaxPoints : int'(cur_count);
    for (int i = 0; i < n_items; i++) begin
      k = $urandom_range(99);
      if (k < 20) begin
        j = (n > 0) ? $urandom_range(n - 1) : $urandom_range(filled - 1);
        // clear masks half the time so queries keep finding points
        send_cmd(nups_pkg::FuncLoad, j[9:0], 8'($urandom), 8'($urandom), 8'($urandom),
                 ($urandom_range(1) != 0) ? 64'd0 : {$urandom, $urandom}, idle_pct);
      end else if (k < 65) begin
        send_cmd(nups_pkg::FuncNear, 10'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), {$urandom, $urandom}, idle_pct);
      end else if (k < 92 && n > 0) begin
        j = $urandom_range(n - 1);
        send_cmd(nups_pkg::FuncMark, 10'($urandom), tbl_x[j], tbl_y[j], tbl_z[j],
                 {$urandom, $urandom}, idle_pct);
      end else begin
        f = (k < 97) ? nups_pkg::FuncMark : FuncNone;
        send_cmd(f, 10'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 {$urandom, $urandom}, idle_pct);
      end
    end
  endtask

  // results cannot be held off, so compare on every strobe
  always @(posedge clk_i) begin
    hit_t want;
    if (rst_ni && done_o) begin
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        want = pending_hits.pop_front();
        if (found_o !== want.found || hit_x_o !== want.x || hit_y_o !== want.y
            || hit_z_o !== want.z || hit_index_o !== want.idx) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: expected %0d (%0d,%0d,%0d) @%0d, got %0d (%0d,%0d,%0d) @%0d",
                     $realtime, want.found, want.x, want.y, want.z, want.idx,
                     found_o, hit_x_o, hit_y_o, hit_z_o, hit_index_o);
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    row_t r;
    for (int i = 0; i < nups_pkg::MaxPoints; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_z[i] = '0;
      tbl_mask[i] = '0;
    end
    cur_owner = '0;
    cur_count = '0;

    // directed: empty table, then a handful of extreme points
    add_op(nups_pkg::FuncNear, 10'd0, 8'd0, 8'd0, 8'd0, 64'd0, 1);
    add_op(nups_pkg::FuncMark, 10'd1023, 8'd0, 8'd0, 8'd0, 64'd0, 1);
    add_op(FuncNone, 10'd1023, 8'd255, 8'd255, 8'd255, '1, 1);
    add_op(nups_pkg::FuncLoad, 10'd0, 8'd0, 8'd0, 8'd0, 64'd0, 1);
    add_op(nups_pkg::FuncLoad, 10'd1, 8'd255, 8'd255, 8'd255, 64'd0, 1);
    add_op(nups_pkg::FuncLoad, 10'd2, 8'd255, 8'd0, 8'd0, '1, 1);
    add_op(nups_pkg::FuncLoad, 10'd3, 8'd0, 8'd0, 8'd0, 64'd0, 1);
    add_op(nups_pkg::FuncLoad, 10'd1023, 8'd128, 8'd128, 8'd128,
           64'hAAAA_AAAA_AAAA_AAAA, 1);
    add_cfg(nups_pkg::CfgCount, 11'd4);
    add_op(nups_pkg::FuncNear, 10'd5, 8'd0, 8'd0, 8'd0, '1);
    add_op(nups_pkg::FuncNear, 10'd0, 8'd0, 8'd0, 8'd0, 64'd0);   // slot 0 now marked, so its twin slot 3
    add_op(nups_pkg::FuncNear, 10'd0, 8'd0, 8'd0, 8'd0, 64'd0);   // farthest corner
    add_op(nups_pkg::FuncNear, 10'd0, 8'd0, 8'd0, 8'd0, 64'd0);   // all marked now
    add_op(nups_pkg::FuncMark, 10'd0, 8'd255, 8'd0, 8'd0, 64'd0); // already marked
    add_op(nups_pkg::FuncMark, 10'd0, 8'd1, 8'd2, 8'd3, 64'd0);
    add_cfg(nups_pkg::CfgOwner, 11'd63);
    add_op(nups_pkg::FuncNear, 10'd0, 8'd255, 8'd255, 8'd255, 64'd0);
    add_op(nups_pkg::FuncMark, 10'd0, 8'd0, 8'd0, 8'd0, 64'd0);
    add_op(FuncNone, 10'd512, 8'd1, 8'd2, 8'd3, 64'h5555_5555_5555_5555);
    add_cfg(nups_pkg::CfgCount, 11'd0);
    add_op(nups_pkg::FuncNear, 10'd0, 8'd255, 8'd255, 8'd255, 64'd0, 1);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.cfg) cfg_write(r.cidx, r.cdata);
      else send_cmd(r.func, r.slot, r.x, r.y, r.z, r.mask, 0, r.typed, r.hit);
    end
    filled = 4;

    // no gaps
    fill_to(16, 0);
    cfg_write(nups_pkg::CfgOwner, 11'd0);
    cfg_write(nups_pkg::CfgCount, 11'd16);
    random_phase(0, 120);
    // sender idle often
    fill_to(48, 54);
    cfg_write(nups_pkg::CfgOwner, 11'd63);
    cfg_write(nups_pkg::CfgCount, 11'($urandom_range(1, 48)));
    random_phase(54, 120);
    // receiver cannot stall, so this phase runs without gaps
    fill_to(64, 0);
    cfg_write(nups_pkg::CfgOwner, 11'($urandom_range(63)));
    cfg_write(nups_pkg::CfgCount, 11'd64);
    random_phase(0, 110);
    // larger table, then a single slot
    fill_to(128, 26);
    cfg_write(nups_pkg::CfgOwner, 11'($urandom_range(63)));
    cfg_write(nups_pkg::CfgCount, 11'd128);
    random_phase(26, 40);
    cfg_write(nups_pkg::CfgOwner, 11'd0);
    cfg_write(nups_pkg::CfgCount, 11'd1);
    random_phase(26, 40);

    if (start) start <= 1'b0;
    @(posedge clk_i);
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ===== nearest_unmarked_point_search.f =====
+incdir+rtl
rtl/nups_pkg.sv
rtl/nups_cell.sv
rtl/nearest_unmarked_point_search.sv
rtl/nups_checker.sv
tb/nearest_unmarked_point_search_test.sv
